[rtl/core/wpnr_pkg.sv]
// Shared types and constants for the weighted pick without repeat block.
// Used by wpnr_cell and weighted_pick_no_repeat; depends on nothing else.
`timescale 1ns / 1ps

package wpnr_pkg;

  // Field widths fixed by the item formats.
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned DRAW_W   = 20;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned EIDX_W   = 4;
  localparam int unsigned COUNT_W  = 5;

  // Entry index and running sum are sized for the largest supported table (64 entries).
  localparam int unsigned IDX_W = 6;
  localparam int unsigned RUN_W = WEIGHT_W + IDX_W;

  // Request codes carried in the input beat.
  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD  = 2'd0,
    REQ_PICK  = 2'd1,
    REQ_NOREP = 2'd2,
    REQ_NONE  = 2'd3
  } wpnr_req_e;

  // Scan token handed from cell to cell along the chain.
  typedef struct packed {
    logic             valid;
    logic [RUN_W-1:0] run;       // running weight sum
    logic             hit;       // draw fell below the running sum
    logic [IDX_W-1:0] pick;      // first entry that took the draw
    logic             aft_v;     // unused entry found at or after the pick
    logic [IDX_W-1:0] aft_idx;
    logic             free_v;    // unused entry found anywhere in use
    logic [IDX_W-1:0] free_idx;
  } wpnr_token_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic                wr;
    logic [IDX_W-1:0]    wr_idx;
    logic [WEIGHT_W-1:0] wr_weight;
    logic                mark;
    logic [IDX_W-1:0]    mark_idx;
    logic                clr_all;
  } wpnr_cmd_t;

endpackage

[rtl/core/wpnr_cell.sv]
// One table entry: its weight, its used mark and one hop of the scan chain.
// Depends on wpnr_pkg for the token and command types.
`timescale 1ns / 1ps

module wpnr_cell
  import wpnr_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wpnr_cmd_t           cmd_i,
  input  logic [CNT_W-1:0]    count_i,
  input  logic [DRAW_W-1:0]   draw_i,
  input  wpnr_token_t         tok_i,
  output wpnr_token_t         tok_o
);

  logic [WEIGHT_W-1:0] weight_q;
  logic                used_q;
  logic                tok_valid_q;
  wpnr_token_t         tok_d;
  wpnr_token_t         tok_q;
  logic                active;
  logic [RUN_W-1:0]    sum;
  logic                wr_hit;
  logic                mark_hit;

  assign wr_hit   = cmd_i.wr && (cmd_i.wr_idx == IDX_W'(IDX));
  assign mark_hit = cmd_i.mark_idx == IDX_W'(IDX);

  // Loads clear the mark; a no-repeat pick sets it and may clear the rest.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= '0;
      used_q   <= 1'b0;
    end else if (wr_hit) begin
      weight_q <= cmd_i.wr_weight;
      used_q   <= 1'b0;
    end else if (cmd_i.mark) begin
      if (cmd_i.clr_all) begin
        used_q <= mark_hit;
      end else if (mark_hit) begin
        used_q <= 1'b1;
      end
    end
  end

  // Update the passing token when this entry is in use.
  assign active = tok_i.valid && (int'(count_i) > IDX);
  assign sum    = tok_i.run + RUN_W'(weight_q);

  always_comb begin
    tok_d = tok_i;
    if (active) begin
      tok_d.run = sum;
      if (!tok_i.hit && (RUN_W'(draw_i) < sum)) begin
        tok_d.hit  = 1'b1;
        tok_d.pick = IDX_W'(IDX);
      end
      if (tok_d.hit && !tok_i.aft_v && !used_q) begin
        tok_d.aft_v   = 1'b1;
        tok_d.aft_idx = IDX_W'(IDX);
      end
      if (!tok_i.free_v && !used_q) begin
        tok_d.free_v   = 1'b1;
        tok_d.free_idx = IDX_W'(IDX);
      end
    end
  end

  // Hand the token to the next cell through a register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = tok_valid_q;
  end

endmodule

[rtl/core/weighted_pick_no_repeat.sv]
// Top level of the weighted pick without repeat block: controller and cell chain.
// Depends on wpnr_pkg and wpnr_cell.
`timescale 1ns / 1ps

// Weighted random pick over a table of up to MAX_ENTRIES weights, with an
// optional no-repeat mode that marks chosen entries as used. A load beat
// writes one weight and returns nothing; an unknown request is dropped. A
// pick beat returns one result beat: a start state launches a token, the
// token walks the chain of entry cells one cell per cycle, summing weights
// and noting the pick and the first unused entries, and a resolve state then
// forms the result and updates the marks. One item is worked on at a time;
// the input takes the next beat while a result still waits at the output.
// entry_count may be written only while the block is idle and is saturated
// to MAX_ENTRIES. A draw at or above the total weight picks entry 0 in pick
// mode and the first unused entry (entry 0 if none) in no-repeat mode.
module weighted_pick_no_repeat
  import wpnr_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input beat, from bit 0: entry_index[4], entry_weight[16], random_value[20].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  // Input sideband, from bit 0: req_type[2].
  input  logic [1:0]  s_axis_tuser,
  // Result beat, from bit 0: found[1], chosen_index[4], marks_were_reset[1],
  // zero pad[2].
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,
  // entry_count register write.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [COUNT_W-1:0] cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_RESOLVE
  } state_e;

  state_e             state_q;
  logic [COUNT_W-1:0] entry_count_q;
  logic [CNT_W-1:0]   count_live;
  logic [CNT_W-1:0]   cnt_q;
  logic [DRAW_W-1:0]  draw_q;
  logic               norep_q;
  wpnr_token_t        tail_q;
  logic               out_found_q;
  logic [EIDX_W-1:0]  out_chosen_q;
  logic               out_reset_q;
  logic               m_valid_q;

  wpnr_req_e          in_req;
  logic [EIDX_W-1:0]  in_idx;
  logic [WEIGHT_W-1:0] in_weight;
  logic [DRAW_W-1:0]  in_draw;
  logic               in_fire;
  logic               can_emit;

  wpnr_token_t        tok [MAX_ENTRIES+1];
  wpnr_cmd_t          cmd;

  logic               res_found;
  logic [IDX_W-1:0]   res_chosen;
  logic               res_reset;
  logic               res_mark;

  // Unpack the input beat.
  assign in_req    = wpnr_req_e'(s_axis_tuser);
  assign in_idx    = s_axis_tdata[3:0];
  assign in_weight = s_axis_tdata[19:4];
  assign in_draw   = s_axis_tdata[39:20];

  assign s_axis_tready = state_q == S_IDLE;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign can_emit      = !m_valid_q || m_axis_tready;

  // Configuration register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      entry_count_q <= cfg_data_i;
    end
  end

  // Entries in use, capped at the table size.
  always_comb begin
    if (32'(entry_count_q) > MAX_ENTRIES) begin
      count_live = CNT_W'(MAX_ENTRIES);
    end else begin
      count_live = CNT_W'(entry_count_q);
    end
  end

  // Token entering the first cell.
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = state_q == S_START;
  end

  // Chain of entry cells.
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    wpnr_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .count_i (cnt_q),
      .draw_i  (draw_q),
      .tok_i   (tok[g]),
      .tok_o   (tok[g+1])
    );
  end

  // Resolve the finished token into a result and a mark update.
  always_comb begin
    res_found  = (cnt_q != '0) && (tail_q.run != '0);
    res_chosen = '0;
    res_reset  = 1'b0;
    res_mark   = 1'b0;
    if (res_found && (cnt_q != CNT_W'(1))) begin
      res_chosen = tail_q.hit ? tail_q.pick : '0;
      if (norep_q) begin
        res_mark = 1'b1;
        if (tail_q.hit && tail_q.aft_v) begin
          res_chosen = tail_q.aft_idx;
        end else if (tail_q.free_v) begin
          res_chosen = tail_q.free_idx;
        end else begin
          res_reset = 1'b1;
        end
      end
    end
  end

  // Command broadcast to the cells.
  always_comb begin
    cmd           = '0;
    cmd.wr        = in_fire && (in_req == REQ_LOAD);
    cmd.wr_idx    = IDX_W'(in_idx);
    cmd.wr_weight = in_weight;
    cmd.mark      = (state_q == S_RESOLVE) && can_emit && res_mark;
    cmd.mark_idx  = res_chosen;
    cmd.clr_all   = res_reset;
  end

  // Controller and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      draw_q       <= '0;
      norep_q      <= 1'b0;
      tail_q       <= '0;
      m_valid_q    <= 1'b0;
      out_found_q  <= 1'b0;
      out_chosen_q <= '0;
      out_reset_q  <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire && ((in_req == REQ_PICK) || (in_req == REQ_NOREP))) begin
            cnt_q   <= count_live;
            draw_q  <= in_draw;
            norep_q <= in_req == REQ_NOREP;
            state_q <= S_START;
          end
        end
        S_START: begin
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (tok[MAX_ENTRIES].valid) begin
            tail_q  <= tok[MAX_ENTRIES];
            state_q <= S_RESOLVE;
          end
        end
        S_RESOLVE: begin
          if (can_emit) begin
            m_valid_q    <= 1'b1;
            out_found_q  <= res_found;
            out_chosen_q <= res_chosen[EIDX_W-1:0];
            out_reset_q  <= res_reset;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, out_reset_q, out_chosen_q, out_found_q};

  // The scan token reaches the end of the chain only while the controller waits for it.
  a_tail_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[MAX_ENTRIES].valid |-> state_q == S_SCAN)
    else $error("scan token left the chain outside the scan state");

  // A weight load and a mark update never land on the cells together.
  a_no_wr_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.wr && cmd.mark))
    else $error("load and mark update in the same cycle");

  // A mark update is followed by a result beat being presented.
  a_mark_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mark |=> m_axis_tvalid && m_axis_tdata[0])
    else $error("mark update without a found result");

  // A not-found result carries a zero index and no mark reset.
  a_not_found_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[5:1] == 5'd0))
    else $error("not-found result with nonzero index or reset flag");

endmodule
